// ===== src/skce_pkg.sv =====
// Shared types and constants for the strided key candidate enumerator.
`timescale 1ns / 1ps
`default_nettype none

package skce_pkg;

   localparam int CHARSET_DEPTH_DEFAULT = 256;
   localparam int MAX_KEY_DEFAULT       = 16;
   localparam int CMD_QUEUE_DEPTH       = 4;
   localparam int RSP_QUEUE_DEPTH       = 4;
   localparam int CSR_INDEX_WIDTH       = 2;
   localparam int CSR_DATA_WIDTH        = 9;

   localparam logic [1:0] MODE_LOAD    = 2'd0;
   localparam logic [1:0] MODE_EMIT    = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CHARSET_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MAX_KEY_LENGTH = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STRIDE         = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WORKER_OFFSET  = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] load_index;
      logic [7:0] load_char;
   } req_type;

   typedef struct packed {
      logic [7:0] key_char;
      logic [3:0] char_position;
      logic [4:0] key_length;
      logic       last;
      logic       finished;
   } rsp_type;

   typedef struct packed {
      logic [8:0] charset_length;
      logic [4:0] max_key_length;
      logic [8:0] stride;
      logic [7:0] worker_offset;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_EMIT,
      OP_RESTART
   } cmd_op_type;

   typedef struct packed {
      logic       valid;
      cmd_op_type op;
      logic [7:0] index;
      logic [7:0] data;
   } cmd_type;

   typedef struct packed {
      logic [3:0] char_position;
      logic [4:0] key_length;
      logic       last;
   } meta_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STREAM,
      ST_ADV_RD,
      ST_ADV_UP
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/skce_front.sv =====
// Front part: accepts request items, classifies them and queues the commands.
`timescale 1ns / 1ps
`default_nettype none

module skce_front #(
   parameter int CHARSET_DEPTH = skce_pkg::CHARSET_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire skce_pkg::req_type req_payload,
   output skce_pkg::cmd_type      cmd,
   input  wire logic              cmd_pop
);
   import skce_pkg::*;

   localparam int QAW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(CMD_QUEUE_DEPTH + 1);
   localparam logic [9:0] DEPTH_LIMIT = 10'(CHARSET_DEPTH);

   cmd_type          q_mem [CMD_QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             keep;
   cmd_op_type       op;
   logic             in_range;
   logic             push;
   logic             pop;
   cmd_type          entry;

   assign in_range  = {2'b00, req_payload.load_index} < DEPTH_LIMIT;
   assign req_stall = (count_ff == QCW'(CMD_QUEUE_DEPTH));

   always_comb begin
      keep = 1'b0;
      op   = OP_LOAD;
      unique case (req_payload.mode)
         MODE_LOAD: begin
            keep = in_range;
            op   = OP_LOAD;
         end
         MODE_EMIT: begin
            keep = 1'b1;
            op   = OP_EMIT;
         end
         MODE_RESTART: begin
            keep = 1'b1;
            op   = OP_RESTART;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_valid && !req_stall && keep;
   assign pop  = cmd_pop && (count_ff != '0);

   assign entry.valid = 1'b1;
   assign entry.op    = op;
   assign entry.index = req_payload.load_index;
   assign entry.data  = req_payload.load_char;

   always_comb begin
      cmd       = q_mem[rd_ptr_ff];
      cmd.valid = (count_ff != '0);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      count_in = count_ff + QCW'(push) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= entry;
      end
   end

endmodule

`default_nettype wire

// ===== src/skce_back.sv =====
// Back part: charset and digit stores, key streaming, odometer advance and result queue.
`timescale 1ns / 1ps
`default_nettype none

module skce_back #(
   parameter int CHARSET_DEPTH = skce_pkg::CHARSET_DEPTH_DEFAULT,
   parameter int MAX_KEY       = skce_pkg::MAX_KEY_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire skce_pkg::cfg_type cfg,
   input  wire skce_pkg::cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output skce_pkg::rsp_type      rsp_payload
);
   import skce_pkg::*;

   localparam int CIW = (CHARSET_DEPTH > 1) ? $clog2(CHARSET_DEPTH) : 1;
   localparam int KW  = (MAX_KEY > 1) ? $clog2(MAX_KEY) : 1;
   localparam int LW  = $clog2(MAX_KEY + 1);
   localparam int MW  = ((LW > 5) ? LW : 5) + 1;
   localparam int PW  = ((CIW > 9) ? CIW : 9) + 2;
   localparam int OAW = (RSP_QUEUE_DEPTH > 1) ? $clog2(RSP_QUEUE_DEPTH) : 1;
   localparam int OCW = $clog2(RSP_QUEUE_DEPTH + 1);
   localparam int CRW = OCW + 1;

   back_state_type state_ff, state_in;
   logic [LW-1:0]  len_ff, len_in;
   logic           done_ff, done_in;
   logic [KW-1:0]  idx_ff, idx_in;
   logic           s1_valid_ff, s1_valid_in;
   meta_type       s1_meta_ff, s1_meta_in;
   logic           s2_valid_ff, s2_valid_in;
   meta_type       s2_meta_ff, s2_meta_in;

   logic [CIW-1:0] dig_mem [MAX_KEY];
   logic [CIW-1:0] dig_rd_ff;
   logic [KW-1:0]  dig_raddr;
   logic           dig_we;
   logic [CIW-1:0] dig_wdata;

   logic [7:0]     cs_mem [CHARSET_DEPTH];
   logic [7:0]     cs_rd_ff;
   logic           cs_we;
   logic [CIW-1:0] cs_waddr;

   rsp_type        oq_mem [RSP_QUEUE_DEPTH];
   logic [OAW-1:0] oq_wr_ff, oq_wr_in;
   logic [OAW-1:0] oq_rd_ff, oq_rd_in;
   logic [OCW-1:0] oq_count_ff, oq_count_in;
   logic           oq_push;
   logic           oq_pop;
   rsp_type        oq_data;

   logic [PW-1:0]  clen;
   logic [MW-1:0]  maxe_cap;
   logic [MW-1:0]  maxe;
   logic           bad_offset;
   logic           credit_ok;
   logic           idx_last;
   logic           is_first;
   logic [PW-1:0]  start;
   logic           extend;
   logic [PW-1:0]  sum;
   logic [PW-1:0]  p_raw;
   logic           wrap;
   logic [PW-1:0]  p_fin;
   logic           at_end;

   assign clen = (PW'(cfg.charset_length) < PW'(CHARSET_DEPTH)) ?
                 PW'(cfg.charset_length) : PW'(CHARSET_DEPTH);
   assign maxe_cap = (MW'(cfg.max_key_length) < MW'(MAX_KEY)) ?
                     MW'(cfg.max_key_length) : MW'(MAX_KEY);
   assign maxe       = (maxe_cap == '0) ? MW'(1) : maxe_cap;
   assign bad_offset = PW'(cfg.worker_offset) >= clen;

   assign credit_ok = (CRW'(oq_count_ff) + CRW'(s1_valid_ff) + CRW'(s2_valid_ff))
                      < CRW'(RSP_QUEUE_DEPTH);
   assign idx_last  = (LW'(idx_ff) + LW'(1)) == len_ff;

   assign is_first = (idx_ff == '0);
   assign start    = is_first ? PW'(cfg.worker_offset) : '0;
   assign extend   = LW'(idx_ff) >= len_ff;
   assign sum      = PW'(dig_rd_ff) + (is_first ? PW'(cfg.stride) : PW'(1));
   assign p_raw    = extend ? start : sum;
   assign wrap     = p_raw >= clen;
   assign p_fin    = wrap ? start : p_raw;
   assign at_end   = (MW'(idx_ff) + MW'(1)) >= maxe;

   assign cs_waddr = CIW'(cmd.index);

   always_comb begin
      state_in    = state_ff;
      len_in      = len_ff;
      done_in     = done_ff;
      idx_in      = idx_ff;
      cmd_pop     = 1'b0;
      dig_we      = 1'b0;
      dig_wdata   = CIW'(p_fin);
      dig_raddr   = idx_ff;
      cs_we       = 1'b0;
      s1_valid_in = 1'b0;
      s1_meta_in  = s1_meta_ff;
      s2_valid_in = s1_valid_ff;
      s2_meta_in  = s1_meta_ff;

      oq_push               = s2_valid_ff;
      oq_data.key_char      = cs_rd_ff;
      oq_data.char_position = s2_meta_ff.char_position;
      oq_data.key_length    = s2_meta_ff.key_length;
      oq_data.last          = s2_meta_ff.last;
      oq_data.finished      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.valid && !s1_valid_ff && !s2_valid_ff) begin
               unique case (cmd.op)
                  OP_LOAD: begin
                     cs_we   = 1'b1;
                     cmd_pop = 1'b1;
                  end
                  OP_RESTART: begin
                     len_in  = '0;
                     done_in = 1'b0;
                     cmd_pop = 1'b1;
                  end
                  OP_EMIT: begin
                     if (oq_count_ff != OCW'(RSP_QUEUE_DEPTH)) begin
                        cmd_pop = 1'b1;
                        idx_in  = '0;
                        if (done_ff || bad_offset) begin
                           done_in          = 1'b1;
                           oq_push          = 1'b1;
                           oq_data          = '0;
                           oq_data.last     = 1'b1;
                           oq_data.finished = 1'b1;
                        end else if (len_ff == '0) begin
                           oq_push      = 1'b1;
                           oq_data      = '0;
                           oq_data.last = 1'b1;
                           state_in     = ST_ADV_RD;
                        end else begin
                           state_in = ST_STREAM;
                        end
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_STREAM: begin
            if (credit_ok) begin
               s1_valid_in              = 1'b1;
               s1_meta_in.char_position = 4'(idx_ff);
               s1_meta_in.key_length    = 5'(len_ff);
               s1_meta_in.last          = idx_last;
               if (idx_last) begin
                  idx_in   = '0;
                  state_in = ST_ADV_RD;
               end else begin
                  idx_in = idx_ff + KW'(1);
               end
            end
         end
         ST_ADV_RD: begin
            state_in = ST_ADV_UP;
         end
         ST_ADV_UP: begin
            dig_we = 1'b1;
            if (extend) begin
               len_in = LW'(idx_ff) + LW'(1);
            end
            if (wrap) begin
               if (at_end) begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + KW'(1);
                  state_in = ST_ADV_RD;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = (oq_count_ff != '0);
   assign rsp_payload = oq_mem[oq_rd_ff];
   assign oq_pop      = rsp_valid && !rsp_stall;

   always_comb begin
      oq_wr_in = oq_wr_ff;
      oq_rd_in = oq_rd_ff;
      if (oq_push) begin
         oq_wr_in = (oq_wr_ff == OAW'(RSP_QUEUE_DEPTH - 1)) ? '0 : oq_wr_ff + OAW'(1);
      end
      if (oq_pop) begin
         oq_rd_in = (oq_rd_ff == OAW'(RSP_QUEUE_DEPTH - 1)) ? '0 : oq_rd_ff + OAW'(1);
      end
      oq_count_in = oq_count_ff + OCW'(oq_push) - OCW'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         len_ff      <= '0;
         done_ff     <= 1'b0;
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         state_ff    <= state_in;
         len_ff      <= len_in;
         done_ff     <= done_in;
         idx_ff      <= idx_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         oq_wr_ff    <= oq_wr_in;
         oq_rd_ff    <= oq_rd_in;
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff <= s1_meta_in;
      s2_meta_ff <= s2_meta_in;
      if (oq_push) begin
         oq_mem[oq_wr_ff] <= oq_data;
      end
   end

   always_ff @(posedge clock) begin
      if (dig_we) begin
         dig_mem[idx_ff] <= dig_wdata;
      end
      dig_rd_ff <= dig_mem[dig_raddr];
   end

   always_ff @(posedge clock) begin
      if (cs_we) begin
         cs_mem[cs_waddr] <= cmd.data;
      end
      cs_rd_ff <= cs_mem[dig_rd_ff];
   end

endmodule

`default_nettype wire

// ===== src/strided_key_candidate_enumerator.sv =====
// Top level of the strided key candidate enumerator: register port, front and back parts.
//
// Request items carry a mode: load writes one charset byte, restart clears the key,
// emit returns the current key and then advances it. An item is taken on req_valid
// while req_stall is low; a four-entry command queue parts the front from the back.
// Result items leave on rsp_valid, one character per item, with last on the final
// character; an empty key or an exhausted enumeration gives a single item.
// Loads and restarts give no result. An emit of a key of length L streams L results,
// one per cycle while the result queue has room, each through a digit store read and
// a charset read; it then advances the key with a read state and an update state for
// each digit that the carry visits, as the digit store has a single read port, and
// takes no new command until done. Registers are written through csr_wr_en, csr_index
// and csr_data; the user writes them only while idle, which the block does not enforce.
// Reset clears the key, the finished flag and both queues and returns the registers
// to their defaults; the charset store holds no defined contents until loaded.
// A stalled receiver holds the front result; the back part keeps working until its
// four-entry result queue fills, and the command queue then raises req_stall.
`timescale 1ns / 1ps
`default_nettype none

module strided_key_candidate_enumerator #(
   parameter int CHARSET_DEPTH = skce_pkg::CHARSET_DEPTH_DEFAULT,
   parameter int MAX_KEY       = skce_pkg::MAX_KEY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire skce_pkg::req_type                   req_payload,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output skce_pkg::rsp_type                        rsp_payload,
   input  wire logic                                csr_wr_en,
   input  wire logic [skce_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [skce_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import skce_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type cmd;
   logic    cmd_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CHARSET_LENGTH: cfg_in.charset_length = csr_data;
            CSR_MAX_KEY_LENGTH: cfg_in.max_key_length = csr_data[4:0];
            CSR_STRIDE:         cfg_in.stride         = csr_data;
            CSR_WORKER_OFFSET:  cfg_in.worker_offset  = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.charset_length <= 9'd1;
         cfg_ff.max_key_length <= 5'd1;
         cfg_ff.stride         <= 9'd1;
         cfg_ff.worker_offset  <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   skce_front #(
      .CHARSET_DEPTH(CHARSET_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   skce_back #(
      .CHARSET_DEPTH(CHARSET_DEPTH),
      .MAX_KEY      (MAX_KEY)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

// ===== src/skce_checker.sv =====
// Port-level checks on the result channel of the enumerator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module skce_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire skce_pkg::rsp_type rsp_payload
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed or vanished");

   a_finished_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.finished |->
         rsp_payload.last && (rsp_payload.key_length == 5'd0))
      else $error("finished item is not a lone empty item");

   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.key_length == 5'd0) |->
         rsp_payload.last && (rsp_payload.char_position == 4'd0))
      else $error("empty key item is malformed");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.key_length != 5'd0) && (rsp_payload.key_length <= 5'd16) |->
         ({1'b0, rsp_payload.char_position} < rsp_payload.key_length))
      else $error("character position beyond key length");

endmodule

bind strided_key_candidate_enumerator skce_checker u_skce_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

`default_nettype wire

// ===== bench/skce_checker.sv =====
// Checker for the key candidate enumerator: mirrors its state, predicts every result item and compares.
`timescale 1ns / 1ps

module skce_scoreboard (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  skce_pkg::req_type                    req_payload,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  skce_pkg::rsp_type                    rsp_payload,
   input  logic                                 csr_wr_en,
   input  logic [skce_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [skce_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   output int                                   failures,
   output int                                   pending,
   output int                                   emits_seen,
   output int                                   results_seen,
   output int                                   exhausted_seen,
   output int                                   longest_key
);

   import skce_pkg::*;

   localparam int DEPTH = CHARSET_DEPTH_DEFAULT;
   localparam int KEYS  = MAX_KEY_DEFAULT;

   logic [7:0] charset_copy [DEPTH];
   logic [7:0] digits [KEYS];
   int         key_len;
   bit         exhausted;
   cfg_type    settings;
   rsp_type    key_chars_due [$];

   initial begin
      foreach (charset_copy[i]) charset_copy[i] = '0;
      failures       = 0;
      pending        = 0;
      emits_seen     = 0;
      results_seen   = 0;
      exhausted_seen = 0;
      longest_key    = 0;
   end

   function automatic rsp_type make_result(input logic [7:0] ch, input int pos, input int len,
                                           input bit lst, input bit fin);
      rsp_type r;
      r.key_char      = ch;
      r.char_position = 4'(pos);
      r.key_length    = 5'(len);
      r.last          = lst;
      r.finished      = fin;
      return r;
   endfunction

   task automatic advance_odometer(input int clen, input int maxe);
      int n;
      int start;
      int p;
      bit carry;
      n     = 0;
      carry = 1'b1;
      while (carry) begin
         start = (n == 0) ? int'(settings.worker_offset) : 0;
         if (n >= key_len) begin
            key_len = n + 1;
            p       = start;
         end else begin
            p = int'(digits[n]) + ((n == 0) ? int'(settings.stride) : 1);
         end
         if (p >= clen) p = start;
         else carry = 1'b0;
         digits[n] = 8'(p);
         n++;
         if (carry && n >= maxe) begin
            exhausted = 1'b1;
            return;
         end
      end
   endtask

   task automatic predict_request(input req_type item);
      int clen;
      int maxe;
      int i;
      case (item.mode)
         MODE_LOAD: begin
            charset_copy[item.load_index] = item.load_char;
         end
         MODE_RESTART: begin
            foreach (digits[k]) digits[k] = '0;
            key_len   = 0;
            exhausted = 1'b0;
         end
         MODE_EMIT: begin
            emits_seen++;
            clen = (settings.charset_length > DEPTH) ? DEPTH : int'(settings.charset_length);
            maxe = (settings.max_key_length > KEYS) ? KEYS : int'(settings.max_key_length);
            if (maxe == 0) maxe = 1;
            if (exhausted || settings.worker_offset >= clen) begin
               exhausted = 1'b1;
               exhausted_seen++;
               key_chars_due.push_back(make_result(8'h00, 0, 0, 1'b1, 1'b1));
            end else begin
               if (key_len == 0) begin
                  key_chars_due.push_back(make_result(8'h00, 0, 0, 1'b1, 1'b0));
               end else begin
                  for (i = 0; i < key_len; i++)
                     key_chars_due.push_back(make_result(charset_copy[digits[i]], i, key_len,
                                                         (i + 1 == key_len), 1'b0));
               end
               if (key_len > longest_key) longest_key = key_len;
               advance_odometer(clen, maxe);
            end
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         foreach (digits[k]) digits[k] = '0;
         key_len                 = 0;
         exhausted               = 1'b0;
         settings.charset_length = 9'd1;
         settings.max_key_length = 5'd1;
         settings.stride         = 9'd1;
         settings.worker_offset  = 8'd0;
         key_chars_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_payload;
            results_seen++;
            if (key_chars_due.size() == 0) begin
               $display("%0t: result item with none due: char %h pos %0d len %0d last %b fin %b",
                        $time, got.key_char, got.char_position, got.key_length, got.last,
                        got.finished);
               failures++;
            end else begin
               want = key_chars_due.pop_front();
               if (got.key_char !== want.key_char || got.char_position !== want.char_position ||
                   got.key_length !== want.key_length || got.last !== want.last ||
                   got.finished !== want.finished) begin
                  $display("%0t: mismatch: expected char %h pos %0d len %0d last %b fin %b",
                           $time, want.key_char, want.char_position, want.key_length,
                           want.last, want.finished);
                  $display("%0t:           actual   char %h pos %0d len %0d last %b fin %b",
                           $time, got.key_char, got.char_position, got.key_length,
                           got.last, got.finished);
                  failures++;
               end
            end
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CHARSET_LENGTH: settings.charset_length = csr_data[8:0];
               CSR_MAX_KEY_LENGTH: settings.max_key_length = csr_data[4:0];
               CSR_STRIDE:         settings.stride         = csr_data[8:0];
               CSR_WORKER_OFFSET:  settings.worker_offset  = csr_data[7:0];
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) predict_request(req_payload);
      end
      pending = key_chars_due.size();
   end

endmodule

// ===== bench/strided_key_candidate_enumerator_test.sv =====
// Testbench top for the key candidate enumerator: clock, reset, stimulus phases and verdict.
`timescale 1ns / 1ps

module strided_key_candidate_enumerator_test;

   import skce_pkg::*;

   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;
   logic    csr_wr_en;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_data;

   int failures;
   int pending;
   int emits_seen;
   int results_seen;
   int exhausted_seen;
   int longest_key;

   int cycle_count = 0;
   int items_sent  = 0;
   int settings_used = 0;
   int hold_left = 0;
   bit calm = 1'b0;
   bit squeeze = 1'b0;
   bit squeezed = 1'b0;
   bit loaded [CHARSET_DEPTH_DEFAULT];

   strided_key_candidate_enumerator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   skce_scoreboard scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .failures       (failures),
      .pending        (pending),
      .emits_seen     (emits_seen),
      .results_seen   (results_seen),
      .exhausted_seen (exhausted_seen),
      .longest_key    (longest_key)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d result items outstanding.",
                  cycle_count, pending);
         $display("== FAIL ==");
         $finish;
      end
   end

   // The receiver stalls in short random bursts, once in a long stretch, and not at all when calm.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (squeeze && !squeezed) begin
         squeezed  <= 1'b1;
         hold_left <= 100;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
         hold_left <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic send_op(input logic [1:0] mode, input int idx, input int ch);
      req_type item;
      int gap;
      item.mode       = mode;
      item.load_index = 8'(idx);
      item.load_char  = 8'(ch);
      if (mode == MODE_LOAD) loaded[item.load_index] = 1'b1;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_WIDTH'(value);
   endtask

   task automatic run_phase(input int clen, input int maxk, input int strd, input int offs,
                            input int count, input int straight);
      int top_entry;
      int r;
      int i;
      drain();
      write_reg(CSR_CHARSET_LENGTH, clen);
      write_reg(CSR_MAX_KEY_LENGTH, maxk);
      write_reg(CSR_STRIDE, strd);
      write_reg(CSR_WORKER_OFFSET, offs);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      settings_used++;
      send_op(MODE_RESTART, $urandom, $urandom);
      top_entry = (clen > CHARSET_DEPTH_DEFAULT) ? CHARSET_DEPTH_DEFAULT : clen;
      // A phase reaches only the low entries and the first digit's start entry.
      for (i = 0; i < top_entry; i++)
         if (!loaded[i] && (i <= count + straight || i == offs)) send_op(MODE_LOAD, i, $urandom);
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 62) send_op(MODE_EMIT, $urandom, $urandom);
         else if (r < 85) send_op(MODE_LOAD, $urandom, $urandom);
         else if (r < 91) send_op(MODE_RESTART, $urandom, $urandom);
         else send_op(MODE_IGNORED, $urandom, $urandom);
      end
      if (straight > 0) begin
         send_op(MODE_RESTART, $urandom, $urandom);
         repeat (straight) send_op(MODE_EMIT, $urandom, $urandom);
      end
   endtask

   initial begin
      int c;
      foreach (loaded[i]) loaded[i] = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Default settings: empty key, one-character key, exhaustion and ignored items.
      send_op(MODE_LOAD, 0, 8'hFF);
      send_op(MODE_EMIT, 0, 0);
      send_op(MODE_EMIT, 255, 255);
      send_op(MODE_EMIT, 0, 0);
      send_op(MODE_IGNORED, 255, 255);
      send_op(MODE_EMIT, 255, 0);
      send_op(MODE_RESTART, 0, 0);
      send_op(MODE_EMIT, 170, 85);
      send_op(MODE_LOAD, 255, 0);
      send_op(MODE_LOAD, 128, 8'h7F);
      send_op(MODE_EMIT, 85, 170);
      send_op(MODE_EMIT, 0, 255);
      send_op(MODE_RESTART, 255, 0);
      send_op(MODE_IGNORED, 0, 0);
      settings_used++;

      run_phase(3, 4, 1, 0, 25, 0);
      run_phase(4, 3, 2, 1, 25, 0);
      run_phase(2, 2, 1, 0, 20, 8);
      run_phase(5, 3, 0, 2, 20, 0);
      run_phase(6, 16, 7, 3, 25, 0);
      squeeze <= 1'b1;
      repeat (20) send_op(MODE_EMIT, $urandom, $urandom);
      run_phase(0, 1, 1, 0, 10, 0);
      run_phase(3, 2, 1, 5, 10, 0);
      run_phase(511, 31, 256, 255, 30, 0);
      run_phase(256, 16, 256, 0, 20, 0);
      run_phase(7, 0, 3, 2, 20, 0);
      run_phase(1, 16, 1, 0, 15, 16);
      repeat (3) begin
         c = $urandom_range(1, 12);
         run_phase(c, $urandom_range(1, 6), $urandom_range(0, 5), $urandom_range(0, c), 18, 8);
      end
      calm <= 1'b1;
      run_phase(4, 5, 1, 0, 25, 10);
      drain();

      $display("Sent %0d items under %0d register settings: %0d emits, %0d result items checked.",
               items_sent, settings_used, emits_seen, results_seen);
      $display("Exhausted answers: %0d; longest key returned: %0d characters.",
               exhausted_seen, longest_key);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures.", failures);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
